/* hdl/ntc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared widths, constants, codes and pipeline tag type for the NTC
// thermistor ADC to temperature converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int ADC_BITS   = 12;
    localparam int BETA_W     = 16;
    localparam int OHM_W      = 20;
    localparam int REFK_W     = 16;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int TEMP_W     = 18;
    localparam int STAT_W     = 2;
    localparam int OUT_W      = TEMP_W + STAT_W;
    localparam int S_DATA_W   = ((ADC_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = ((TEMP_W + 7) / 8) * 8;

    // log2 unit
    localparam int PROD_W     = OHM_W + ADC_BITS;
    localparam int EXP_W      = $clog2(PROD_W);
    localparam int FRAC_W     = 32;
    localparam int LOG_W      = EXP_W + FRAC_W;
    localparam logic [FRAC_W-1:0] LN2_Q32 = 32'd2977044472;

    // dividers
    localparam int INV_W      = 55;
    localparam int DIV_N      = (LOG_W + 16 > INV_W) ? LOG_W + 16 : INV_W;
    localparam int DIV_D      = (BETA_W > REFK_W) ? BETA_W : REFK_W;
    localparam int Y_W        = DIV_N + 2;
    localparam int CK_W       = 17;
    localparam logic [DIV_N-1:0] CENTI_Q48 = DIV_N'(100) << 48;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -18'sd27315;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 18'sd99900;
    localparam logic [CK_W-1:0] KELVIN_OFS = 17'd27315;
    localparam logic [CK_W-1:0] CK_SAT     = 17'd127215;

    localparam logic [STAT_W-1:0] ST_NORMAL = 2'd0;
    localparam logic [STAT_W-1:0] ST_SHORT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_OPEN   = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BETA      = 3'd0,
        REG_NOMINAL   = 3'd1,
        REG_DIVIDER   = 3'd2,
        REG_REFK      = 3'd3,
        REG_AT_BOTTOM = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_NORMAL = 2'd0,
        KIND_SHORT  = 2'd1,
        KIND_OPEN   = 2'd2,
        KIND_HOT    = 2'd3
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  neg;
    } tag_t;

endpackage

/* hdl/ntc_adc_to_temperature_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature_top
// NTC thermistor ADC code to temperature (Beta equation), fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one ADC code per beat (s_tdata[11:0]). m_* returns one result
//   per code: temperature in 0.01 degC on m_tdata[17:0] (two's complement),
//   sensor status on m_tuser (0 normal, 1 shorted, 2 open).
//   Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data);
//   write it only while no beat is in flight.
// Throughput: one code per cycle, sustained while m_tready stays high.
// Pipeline: the 55-stage Q48 restoring divider (ln/Beta term) and the 32
//   squaring stages of the log2 units make up most of the depth; the final
//   reciprocal adds 18 stages.
// Reset: aresetn (synchronous, low) empties the pipeline and loads the
//   register defaults (Beta 3950, R0 10k, divider 10k, T0 298.15 K, bottom).
// Stall: when m_tready drops, the pending result parks in a skid stage and
//   s_tready falls on the next cycle; the whole pipeline then holds, nothing
//   is lost or repeated.
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // cfg_data: register value, low bits used per register
    input  logic                            cfg_wr_en,
    input  logic [ntc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ntc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: [11:0] adc_code, rest zero
    input  logic [ntc_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: [17:0] temp_centi_celsius, rest zero
    output logic [ntc_pkg::M_DATA_W-1:0]    m_tdata,
    // m_tuser: [1:0] sensor_status
    output logic [ntc_pkg::STAT_W-1:0]      m_tuser
);

    localparam int AB = ntc_pkg::ADC_BITS;
    localparam logic [AB-1:0] FS = '1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ntc_pkg::BETA_W-1:0] beta_reg;
    logic [ntc_pkg::OHM_W-1:0]  nominal_reg;
    logic [ntc_pkg::OHM_W-1:0]  divider_reg;
    logic [ntc_pkg::REFK_W-1:0] refk_reg;
    logic                       at_bottom_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg      <= 16'd3950;
            nominal_reg   <= 20'd10000;
            divider_reg   <= 20'd10000;
            refk_reg      <= 16'd29815;
            at_bottom_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ntc_pkg::REG_BETA:      beta_reg      <= cfg_data[ntc_pkg::BETA_W-1:0];
                ntc_pkg::REG_NOMINAL:   nominal_reg   <= cfg_data[ntc_pkg::OHM_W-1:0];
                ntc_pkg::REG_DIVIDER:   divider_reg   <= cfg_data[ntc_pkg::OHM_W-1:0];
                ntc_pkg::REG_REFK:      refk_reg      <= cfg_data[ntc_pkg::REFK_W-1:0];
                ntc_pkg::REG_AT_BOTTOM: at_bottom_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // A zero register acts as one.
    logic [ntc_pkg::BETA_W-1:0] beta_eff;
    logic [ntc_pkg::OHM_W-1:0]  nominal_eff;
    logic [ntc_pkg::OHM_W-1:0]  divider_eff;
    logic [ntc_pkg::REFK_W-1:0] refk_eff;

    assign beta_eff    = (beta_reg == '0)    ? ntc_pkg::BETA_W'(1) : beta_reg;
    assign nominal_eff = (nominal_reg == '0) ? ntc_pkg::OHM_W'(1)  : nominal_reg;
    assign divider_eff = (divider_reg == '0) ? ntc_pkg::OHM_W'(1)  : divider_reg;
    assign refk_eff    = (refk_reg == '0)    ? ntc_pkg::REFK_W'(1) : refk_reg;

    // ------------------------------------------------------------------
    // Global advance: the whole pipeline moves while the skid stage is free.
    // ------------------------------------------------------------------
    logic en;

    assign s_tready = en;

    // ------------------------------------------------------------------
    // S0: classify the code, pick divider ratio terms
    // ------------------------------------------------------------------
    logic [AB-1:0]  code;
    ntc_pkg::tag_t  s0_tag_next;
    ntc_pkg::tag_t  s0_tag_reg;
    logic [AB-1:0]  s0_num_reg;
    logic [AB-1:0]  s0_den_reg;

    assign code = s_tdata[AB-1:0];

    always_comb begin
        s0_tag_next.valid = s_tvalid;
        s0_tag_next.neg   = 1'b0;
        if (code <= AB'(1)) begin
            s0_tag_next.kind = ntc_pkg::KIND_SHORT;
        end else if (code >= (FS - AB'(1))) begin
            s0_tag_next.kind = ntc_pkg::KIND_OPEN;
        end else begin
            s0_tag_next.kind = ntc_pkg::KIND_NORMAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_tag_reg <= '0;
        end else if (en) begin
            s0_tag_reg <= s0_tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_num_reg <= at_bottom_reg ? code : FS - code;
            s0_den_reg <= at_bottom_reg ? FS - code : code;
        end
    end

    // ------------------------------------------------------------------
    // S1: resistor products
    // ------------------------------------------------------------------
    ntc_pkg::tag_t                  s1_tag_reg;
    logic [ntc_pkg::PROD_W-1:0]     s1_prod_a_reg;
    logic [ntc_pkg::PROD_W-1:0]     s1_prod_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg <= '0;
        end else if (en) begin
            s1_tag_reg <= s0_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_prod_a_reg <= ntc_pkg::PROD_W'(divider_eff) * ntc_pkg::PROD_W'(s0_num_reg);
            s1_prod_b_reg <= ntc_pkg::PROD_W'(nominal_eff) * ntc_pkg::PROD_W'(s0_den_reg);
        end
    end

    // ------------------------------------------------------------------
    // log2 of both products; tag travels with the first unit
    // ------------------------------------------------------------------
    logic [ntc_pkg::LOG_W-1:0]  log_a;
    logic [ntc_pkg::LOG_W-1:0]  log_b;
    ntc_pkg::tag_t              log_tag;

    ntc_log2 u_log_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .v_i     (s1_prod_a_reg),
        .tag_i   (s1_tag_reg),
        .log_o   (log_a),
        .tag_o   (log_tag)
    );

    ntc_log2 u_log_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .v_i     (s1_prod_b_reg),
        .tag_i   ('0),
        .log_o   (log_b),
        .tag_o   ()
    );

    // ------------------------------------------------------------------
    // S2: log difference as magnitude and sign
    // ------------------------------------------------------------------
    ntc_pkg::tag_t              s2_tag_next;
    ntc_pkg::tag_t              s2_tag_reg;
    logic [ntc_pkg::LOG_W-1:0]  s2_mag_reg;
    logic                       lt;

    assign lt = log_a < log_b;

    always_comb begin
        s2_tag_next     = log_tag;
        s2_tag_next.neg = lt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_tag_reg <= '0;
        end else if (en) begin
            s2_tag_reg <= s2_tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_mag_reg <= lt ? log_b - log_a : log_a - log_b;
        end
    end

    // ------------------------------------------------------------------
    // S3/S4: scale by ln2 (integer and fraction parts), then sum
    // ------------------------------------------------------------------
    ntc_pkg::tag_t                  s3_tag_reg;
    logic [ntc_pkg::LOG_W-1:0]      s3_p_hi_reg;
    logic [2*ntc_pkg::FRAC_W-1:0]   s3_p_lo_reg;
    ntc_pkg::tag_t                  s4_tag_reg;
    logic [ntc_pkg::LOG_W-1:0]      s4_ln_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_tag_reg <= '0;
            s4_tag_reg <= '0;
        end else if (en) begin
            s3_tag_reg <= s2_tag_reg;
            s4_tag_reg <= s3_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_p_hi_reg <= ntc_pkg::LOG_W'(s2_mag_reg[ntc_pkg::LOG_W-1:ntc_pkg::FRAC_W])
                           * ntc_pkg::LOG_W'(ntc_pkg::LN2_Q32);
            s3_p_lo_reg <= (2*ntc_pkg::FRAC_W)'(s2_mag_reg[ntc_pkg::FRAC_W-1:0])
                           * (2*ntc_pkg::FRAC_W)'(ntc_pkg::LN2_Q32);
            s4_ln_reg   <= s3_p_hi_reg
                           + ntc_pkg::LOG_W'(s3_p_lo_reg[2*ntc_pkg::FRAC_W-1:ntc_pkg::FRAC_W]);
        end
    end

    // ------------------------------------------------------------------
    // ln/Beta in Q48, and 1/T0 in Q48 from the configuration alone
    // ------------------------------------------------------------------
    logic [ntc_pkg::DIV_N-1:0]  ln_term;
    ntc_pkg::tag_t              div_tag;
    logic [ntc_pkg::DIV_N-1:0]  inv0;

    ntc_div u_div_ln (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .dividend_i (ntc_pkg::DIV_N'({s4_ln_reg, 16'd0})),
        .divisor_i  (ntc_pkg::DIV_D'(beta_eff)),
        .tag_i      (s4_tag_reg),
        .quot_o     (ln_term),
        .tag_o      (div_tag)
    );

    // Constant input: this one settles well before any item reaches S5.
    ntc_div u_div_inv0 (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .dividend_i (ntc_pkg::CENTI_Q48),
        .divisor_i  (ntc_pkg::DIV_D'(refk_eff)),
        .tag_i      ('0),
        .quot_o     (inv0),
        .tag_o      ()
    );

    // ------------------------------------------------------------------
    // S5: inverse temperature y; flag y <= 0
    // ------------------------------------------------------------------
    logic signed [ntc_pkg::Y_W-1:0] inv0_s;
    logic signed [ntc_pkg::Y_W-1:0] ln_s;
    logic signed [ntc_pkg::Y_W-1:0] y_sum;
    ntc_pkg::tag_t                  s5_tag_next;
    ntc_pkg::tag_t                  s5_tag_reg;
    logic [ntc_pkg::Y_W-1:0]        s5_y_reg;

    assign inv0_s = $signed({2'b00, inv0});
    assign ln_s   = $signed({2'b00, ln_term});
    assign y_sum  = div_tag.neg ? inv0_s - ln_s : inv0_s + ln_s;

    always_comb begin
        s5_tag_next = div_tag;
        if (div_tag.kind == ntc_pkg::KIND_NORMAL && (y_sum[ntc_pkg::Y_W-1] || y_sum == '0)) begin
            s5_tag_next.kind = ntc_pkg::KIND_HOT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_tag_reg <= '0;
        end else if (en) begin
            s5_tag_reg <= s5_tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_y_reg <= y_sum;
        end
    end

    // ------------------------------------------------------------------
    // S6: rounded dividend 100*2^48 + y/2
    // ------------------------------------------------------------------
    ntc_pkg::tag_t              s6_tag_reg;
    logic [ntc_pkg::Y_W-1:0]    s6_d_reg;
    logic [ntc_pkg::Y_W-1:0]    s6_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_tag_reg <= '0;
        end else if (en) begin
            s6_tag_reg <= s5_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_d_reg <= ntc_pkg::Y_W'(ntc_pkg::CENTI_Q48) + {1'b0, s5_y_reg[ntc_pkg::Y_W-1:1]};
            s6_y_reg <= s5_y_reg;
        end
    end

    // ------------------------------------------------------------------
    // Temperature in 0.01 K
    // ------------------------------------------------------------------
    logic [ntc_pkg::CK_W-1:0]   ck;
    logic                       ck_ovf;
    ntc_pkg::tag_t              rc_tag;

    ntc_recip u_recip (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .dividend_i (s6_d_reg),
        .y_i        (s6_y_reg),
        .tag_i      (s6_tag_reg),
        .ck_o       (ck),
        .ovf_o      (ck_ovf),
        .tag_o      (rc_tag)
    );

    // ------------------------------------------------------------------
    // S7: pick the result, saturate, convert to Celsius
    // ------------------------------------------------------------------
    logic signed [ntc_pkg::TEMP_W-1:0]  temp_next;
    logic [ntc_pkg::STAT_W-1:0]         stat_next;
    logic                               s7_valid_reg;
    logic [ntc_pkg::TEMP_W-1:0]         s7_temp_reg;
    logic [ntc_pkg::STAT_W-1:0]         s7_stat_reg;

    always_comb begin
        case (rc_tag.kind)
            ntc_pkg::KIND_SHORT: begin
                temp_next = ntc_pkg::TEMP_MIN;
                stat_next = ntc_pkg::ST_SHORT;
            end
            ntc_pkg::KIND_OPEN: begin
                temp_next = ntc_pkg::TEMP_MAX;
                stat_next = ntc_pkg::ST_OPEN;
            end
            ntc_pkg::KIND_HOT: begin
                temp_next = ntc_pkg::TEMP_MAX;
                stat_next = ntc_pkg::ST_NORMAL;
            end
            default: begin
                stat_next = ntc_pkg::ST_NORMAL;
                if (ck_ovf || ck >= ntc_pkg::CK_SAT) begin
                    temp_next = ntc_pkg::TEMP_MAX;
                end else begin
                    temp_next = $signed(ntc_pkg::TEMP_W'(ck)
                                        - ntc_pkg::TEMP_W'(ntc_pkg::KELVIN_OFS));
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_valid_reg <= 1'b0;
        end else if (en) begin
            s7_valid_reg <= rc_tag.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s7_temp_reg <= temp_next;
            s7_stat_reg <= stat_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid stage
    // ------------------------------------------------------------------
    logic [ntc_pkg::OUT_W-1:0]          out_data;
    logic signed [ntc_pkg::TEMP_W-1:0]  out_temp;
    logic [ntc_pkg::STAT_W-1:0]         out_stat;

    ntc_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s7_valid_reg),
        .in_data   ({s7_stat_reg, s7_temp_reg}),
        .in_ready  (en),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .out_ready (m_tready)
    );

    assign out_temp = $signed(out_data[ntc_pkg::TEMP_W-1:0]);
    assign out_stat = out_data[ntc_pkg::OUT_W-1:ntc_pkg::TEMP_W];
    assign m_tdata  = ntc_pkg::M_DATA_W'(out_data[ntc_pkg::TEMP_W-1:0]);
    assign m_tuser  = out_stat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_short_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_stat == ntc_pkg::ST_SHORT) |-> (out_temp == ntc_pkg::TEMP_MIN))
        else $error("shorted status without minimum temperature");

    a_open_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_stat == ntc_pkg::ST_OPEN) |-> (out_temp == ntc_pkg::TEMP_MAX))
        else $error("open status without maximum temperature");

    a_temp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_temp >= ntc_pkg::TEMP_MIN && out_temp <= ntc_pkg::TEMP_MAX))
        else $error("temperature outside saturation range");

    a_hold_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("input held without an output stall");

endmodule

/* hdl/ntc_log2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_log2
// Pipelined log2 with a 32-bit fraction: one normalize stage, then one
// squaring stage per fraction bit.
// ----------------------------------------------------------------------------
module ntc_log2 (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [ntc_pkg::PROD_W-1:0]  v_i,
    input  ntc_pkg::tag_t               tag_i,
    output logic [ntc_pkg::LOG_W-1:0]   log_o,
    output ntc_pkg::tag_t               tag_o
);

    localparam int PW = ntc_pkg::PROD_W;
    localparam int EW = ntc_pkg::EXP_W;
    localparam int FW = ntc_pkg::FRAC_W;

    logic [FW-1:0]     m_reg    [0:FW];
    logic [FW-1:0]     frac_reg [0:FW];
    logic [EW-1:0]     e_reg    [0:FW];
    ntc_pkg::tag_t     tag_reg  [0:FW];

    logic [PW-1:0]     norm_x;
    logic [EW-1:0]     norm_e;
    logic [63:0]       norm_wide;

    // Left-justify the value; the shift taken gives the exponent.
    always_comb begin
        norm_x = v_i;
        norm_e = EW'(PW - 1);
        for (int s = EW - 1; s >= 0; s--) begin
            if ((norm_x >> (PW - (1 << s))) == '0) begin
                norm_x = norm_x << (1 << s);
                norm_e = norm_e - EW'(1 << s);
            end
        end
        norm_wide = {norm_x, (64 - PW)'(0)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0] <= '0;
        end else if (en) begin
            tag_reg[0] <= tag_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0]    <= norm_wide[63:32];
            e_reg[0]    <= norm_e;
            frac_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < FW; k++) begin : g_sq
        logic [2*FW-1:0] sq;
        logic [FW:0]     sq_top;
        logic [FW-1:0]   m_next;
        logic            bit_next;

        assign sq       = m_reg[k] * m_reg[k];
        assign sq_top   = sq[2*FW-1:FW-1];
        assign bit_next = sq_top[FW];
        assign m_next   = bit_next ? sq_top[FW:1] : sq_top[FW-1:0];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[k+1] <= '0;
            end else if (en) begin
                tag_reg[k+1] <= tag_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[k+1]    <= m_next;
                e_reg[k+1]    <= e_reg[k];
                frac_reg[k+1] <= {frac_reg[k][FW-2:0], bit_next};
            end
        end
    end

    assign log_o = {e_reg[FW], frac_reg[FW]};
    assign tag_o = tag_reg[FW];

endmodule

/* hdl/ntc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_div
// Pipelined restoring divider, one quotient bit per stage, for a wide
// dividend over a 16-bit divisor.
// ----------------------------------------------------------------------------
module ntc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [ntc_pkg::DIV_N-1:0]   dividend_i,
    input  logic [ntc_pkg::DIV_D-1:0]   divisor_i,
    input  ntc_pkg::tag_t               tag_i,
    output logic [ntc_pkg::DIV_N-1:0]   quot_o,
    output ntc_pkg::tag_t               tag_o
);

    localparam int N = ntc_pkg::DIV_N;
    localparam int D = ntc_pkg::DIV_D;

    logic [D-1:0]   rem_reg [0:N];
    logic [N-1:0]   nq_reg  [0:N];
    ntc_pkg::tag_t  tag_reg [0:N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0] <= '0;
        end else if (en) begin
            tag_reg[0] <= tag_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            nq_reg[0]  <= dividend_i;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [D:0] trial;
        logic [D:0] diff;
        logic       ge;

        assign trial = {rem_reg[k], nq_reg[k][N-1]};
        assign ge    = trial >= {1'b0, divisor_i};
        assign diff  = trial - {1'b0, divisor_i};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[k+1] <= '0;
            end else if (en) begin
                tag_reg[k+1] <= tag_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? diff[D-1:0] : trial[D-1:0];
                nq_reg[k+1]  <= {nq_reg[k][N-2:0], ge};
            end
        end
    end

    assign quot_o = nq_reg[N];
    assign tag_o  = tag_reg[N];

endmodule

/* hdl/ntc_recip.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_recip
// Pipelined short-quotient divider for the final reciprocal; flags a
// quotient that does not fit and yields the low 17 bits otherwise.
// ----------------------------------------------------------------------------
module ntc_recip (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [ntc_pkg::Y_W-1:0]     dividend_i,
    input  logic [ntc_pkg::Y_W-1:0]     y_i,
    input  ntc_pkg::tag_t               tag_i,
    output logic [ntc_pkg::CK_W-1:0]    ck_o,
    output logic                        ovf_o,
    output ntc_pkg::tag_t               tag_o
);

    localparam int W = ntc_pkg::Y_W;
    localparam int Q = ntc_pkg::CK_W;

    logic [W-1:0]   rem_reg [0:Q];
    logic [Q-1:0]   nq_reg  [0:Q];
    logic [W-1:0]   y_reg   [0:Q];
    logic           ovf_reg [0:Q];
    ntc_pkg::tag_t  tag_reg [0:Q];

    logic [W-1:0]   head;

    assign head = dividend_i >> Q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0] <= '0;
        end else if (en) begin
            tag_reg[0] <= tag_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= head;
            nq_reg[0]  <= dividend_i[Q-1:0];
            y_reg[0]   <= y_i;
            ovf_reg[0] <= head >= y_i;
        end
    end

    for (genvar k = 0; k < Q; k++) begin : g_step
        logic [W:0] trial;
        logic [W:0] diff;
        logic       ge;

        assign trial = {rem_reg[k], nq_reg[k][Q-1]};
        assign ge    = trial >= {1'b0, y_reg[k]};
        assign diff  = trial - {1'b0, y_reg[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[k+1] <= '0;
            end else if (en) begin
                tag_reg[k+1] <= tag_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? diff[W-1:0] : trial[W-1:0];
                nq_reg[k+1]  <= {nq_reg[k][Q-2:0], ge};
                y_reg[k+1]   <= y_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    assign ck_o  = nq_reg[Q];
    assign ovf_o = ovf_reg[Q];
    assign tag_o = tag_reg[Q];

endmodule

/* hdl/ntc_skid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_skid
// Output register with a skid stage; upstream ready is a flop.
// ----------------------------------------------------------------------------
module ntc_skid (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic [ntc_pkg::OUT_W-1:0]   in_data,
    output logic                        in_ready,
    output logic                        out_valid,
    output logic [ntc_pkg::OUT_W-1:0]   out_data,
    input  logic                        out_ready
);

    logic                       out_valid_reg;
    logic [ntc_pkg::OUT_W-1:0]  out_data_reg;
    logic                       skid_valid_reg;
    logic [ntc_pkg::OUT_W-1:0]  skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
